// ----- rtl/frame_geometric_transform_assert.svh -----
// Assertion helpers for the frame transform block.
`ifndef FRAME_GEOMETRIC_TRANSFORM_ASSERT_SVH
`define FRAME_GEOMETRIC_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FGT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fgt assertion failed");

// Next-cycle implication, checked out of reset.
`define FGT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fgt assertion failed");

`endif

// ----- rtl/fgt_pkg.sv -----
package fgt_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned SZW  = 9;
  localparam int unsigned NUMW = 2 * SZW;
  localparam int unsigned CNTW = $clog2(NUMW + 1);
  localparam int unsigned PIXW = 24;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW  = $clog2(QDEPTH);

  localparam logic [2:0] MODE_FLIP_H    = 3'd0;
  localparam logic [2:0] MODE_FLIP_V    = 3'd1;
  localparam logic [2:0] MODE_ROT_LEFT  = 3'd2;
  localparam logic [2:0] MODE_ROT_RIGHT = 3'd3;
  localparam logic [2:0] MODE_CROP      = 3'd4;
  localparam logic [2:0] MODE_SCALE     = 3'd5;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH   = 3'd1;
  localparam logic [2:0] REG_IN_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_OUT_WIDTH  = 3'd3;
  localparam logic [2:0] REG_OUT_HEIGHT = 3'd4;
  localparam logic [2:0] REG_ORIGIN_X   = 3'd5;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic [2:0]     mode;
    logic [SZW-1:0] in_width;
    logic [SZW-1:0] in_height;
    logic [SZW-1:0] out_width;
    logic [SZW-1:0] out_height;
    logic [7:0]     origin_x;
    logic [7:0]     origin_y;
  } cfg_t;

  typedef struct packed {
    logic            is_load;
    logic            err;
    logic            last;
    logic [AW-1:0]   addr;
    logic [PIXW-1:0] pix;
  } cmd_t;

  function automatic logic [SZW-1:0] clamp_size(logic [SZW-1:0] v, int unsigned maxv);
    logic [SZW-1:0] res;
    res = v;
    if (v == '0) res = SZW'(1);
    else if (32'(v) > maxv) res = SZW'(maxv);
    return res;
  endfunction

endpackage

// ----- rtl/fgt_ram.sv -----
module fgt_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/fgt_front.sv -----
module fgt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fgt_pkg::cfg_t cfg_i,
  input  logic          push_i,
  input  logic          op_i,
  input  logic [7:0]    in_red_i,
  input  logic [7:0]    in_green_i,
  input  logic [7:0]    in_blue_i,
  output logic          busy_o,
  input  logic          q_full_i,
  output logic          q_push_o,
  output fgt_pkg::cmd_t q_data_o
);
  import fgt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_PUSH = 3'd3;

  logic [2:0]      st_q, st_d;
  logic [SZW-1:0]  row_q, row_d, col_q, col_d;
  logic [SZW-1:0]  r_q, r_d, c_q, c_d;
  logic [NUMW-1:0] nr_q, nr_d, nc_q, nc_d;
  logic [SZW:0]    rr_q, rr_d, rc_q, rc_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]   prod_q, prod_d, coli_q, coli_d;
  logic [AW-1:0]   lptr_q, lptr_d;
  cmd_t            cmd_q, cmd_d;

  logic [SZW-1:0] w, h, cw, ch, ow, oh, r, c;
  logic           wrap, crop_bad, last, accept;
  logic [SZW:0]   tr, tc;
  logic [AW-1:0]  rsel, csel;

  always_comb begin
    w  = clamp_size(cfg_i.in_width, MAX_WIDTH);
    h  = clamp_size(cfg_i.in_height, MAX_HEIGHT);
    cw = clamp_size(cfg_i.out_width, MAX_WIDTH);
    ch = clamp_size(cfg_i.out_height, MAX_HEIGHT);
    if (cfg_i.mode == MODE_ROT_LEFT || cfg_i.mode == MODE_ROT_RIGHT) begin
      ow = h;
      oh = w;
    end else if (cfg_i.mode == MODE_CROP || cfg_i.mode == MODE_SCALE) begin
      ow = cw;
      oh = ch;
    end else begin
      ow = w;
      oh = h;
    end
    wrap = (row_q >= oh) || (col_q >= ow);
    r = wrap ? '0 : row_q;
    c = wrap ? '0 : col_q;
    crop_bad = (cfg_i.mode == MODE_CROP) &&
               (((SZW+1)'(cfg_i.origin_x) + (SZW+1)'(cw) > (SZW+1)'(w)) ||
                ((SZW+1)'(cfg_i.origin_y) + (SZW+1)'(ch) > (SZW+1)'(h)));
    last = (r == oh - SZW'(1)) && (c == ow - SZW'(1));
    accept = push_i && (st_q == ST_IDLE);
  end

  // Source row and column for each mode.
  always_comb begin
    rsel = AW'(r_q);
    csel = AW'(c_q);
    unique case (cfg_i.mode)
      MODE_FLIP_H: begin
        rsel = AW'(r_q);
        csel = AW'(w) - AW'(1) - AW'(c_q);
      end
      MODE_FLIP_V: begin
        rsel = AW'(h) - AW'(1) - AW'(r_q);
        csel = AW'(c_q);
      end
      MODE_ROT_LEFT: begin
        rsel = AW'(h) - AW'(1) - AW'(c_q);
        csel = AW'(r_q);
      end
      MODE_ROT_RIGHT: begin
        rsel = AW'(c_q);
        csel = AW'(w) - AW'(1) - AW'(r_q);
      end
      MODE_CROP: begin
        rsel = AW'(r_q) + AW'(h) - AW'(cfg_i.origin_y) - AW'(ch);
        csel = AW'(cfg_i.origin_x) + AW'(c_q);
      end
      MODE_SCALE: begin
        rsel = AW'(nr_q);
        csel = AW'(nc_q);
      end
      default: begin
        rsel = AW'(r_q);
        csel = AW'(c_q);
      end
    endcase
  end

  always_comb begin
    st_d   = st_q;
    row_d  = row_q;
    col_d  = col_q;
    r_d    = r_q;
    c_d    = c_q;
    nr_d   = nr_q;
    nc_d   = nc_q;
    rr_d   = rr_q;
    rc_d   = rc_q;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    coli_d = coli_q;
    lptr_d = lptr_q;
    cmd_d  = cmd_q;
    tr = '0;
    tc = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_LOAD) begin
            cmd_d  = '{is_load: 1'b1, err: 1'b0, last: 1'b0, addr: '0,
                       pix: {in_red_i, in_green_i, in_blue_i}};
            prod_d = lptr_q;
            coli_d = '0;
            lptr_d = lptr_q + AW'(1);
            st_d   = ST_PUSH;
          end else if (cfg_i.mode > MODE_SCALE) begin
            st_d = ST_IDLE;
          end else if (crop_bad) begin
            cmd_d  = '{is_load: 1'b0, err: 1'b1, last: 1'b1, addr: '0, pix: '0};
            prod_d = '0;
            coli_d = '0;
            st_d   = ST_PUSH;
          end else begin
            cmd_d = '{is_load: 1'b0, err: 1'b0, last: last, addr: '0, pix: '0};
            r_d = r;
            c_d = c;
            // advance in raster order
            if (c + SZW'(1) >= ow) begin
              col_d = '0;
              row_d = (r + SZW'(1) >= oh) ? '0 : r + SZW'(1);
            end else begin
              col_d = c + SZW'(1);
              row_d = r;
            end
            if (cfg_i.mode == MODE_SCALE) begin
              nr_d  = r * h;
              nc_d  = c * w;
              rr_d  = '0;
              rc_d  = '0;
              cnt_d = '0;
              st_d  = ST_DIV;
            end else begin
              st_d = ST_MUL;
            end
          end
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle for both dividers
        tr = {rr_q[SZW-1:0], nr_q[NUMW-1]};
        tc = {rc_q[SZW-1:0], nc_q[NUMW-1]};
        if (tr >= (SZW+1)'(oh)) begin
          rr_d = tr - (SZW+1)'(oh);
          nr_d = {nr_q[NUMW-2:0], 1'b1};
        end else begin
          rr_d = tr;
          nr_d = {nr_q[NUMW-2:0], 1'b0};
        end
        if (tc >= (SZW+1)'(ow)) begin
          rc_d = tc - (SZW+1)'(ow);
          nc_d = {nc_q[NUMW-2:0], 1'b1};
        end else begin
          rc_d = tc;
          nc_d = {nc_q[NUMW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(NUMW - 1)) st_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d = AW'(rsel * AW'(w));
        coli_d = csel;
        st_d   = ST_PUSH;
      end
      ST_PUSH: begin
        if (!q_full_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      row_q  <= '0;
      col_q  <= '0;
      lptr_q <= '0;
    end else begin
      st_q   <= st_d;
      row_q  <= row_d;
      col_q  <= col_d;
      lptr_q <= lptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    c_q    <= c_d;
    nr_q   <= nr_d;
    nc_q   <= nc_d;
    rr_q   <= rr_d;
    rc_q   <= rc_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    coli_q <= coli_d;
    cmd_q  <= cmd_d;
  end

  always_comb begin
    busy_o   = (st_q != ST_IDLE);
    q_push_o = (st_q == ST_PUSH);
    q_data_o = cmd_q;
    q_data_o.addr = prod_q + coli_q;
  end

endmodule

// ----- rtl/fgt_queue.sv -----
module fgt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fgt_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output fgt_pkg::cmd_t data_o
);
  import fgt_pkg::*;

  cmd_t           mem_q [QDEPTH];
  logic [QPW-1:0] wp_q, rp_q;
  logic [QPW:0]   cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (QPW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + QPW'(1);
      if (do_pop) rp_q <= rp_q + QPW'(1);
      cnt_q <= cnt_q + (QPW+1)'(do_push) - (QPW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule

// ----- rtl/fgt_back.sv -----
module fgt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  fgt_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    out_red_o,
  output logic [7:0]    out_green_o,
  output logic [7:0]    out_blue_o,
  output logic          last_o,
  output logic          error_o
);
  import fgt_pkg::*;

  logic [PIXW-1:0] rdata;
  logic            pend_q, pend_err_q, pend_last_q;
  logic            room, take, do_read;
  logic [PIXW-1:0] opix_q [2];
  logic            olast_q [2];
  logic            oerr_q [2];
  logic            owp_q, orp_q;
  logic [1:0]      ocnt_q;
  logic            opush, opop;

  assign room    = ({1'b0, ocnt_q} + {2'b0, pend_q}) < 3'd2;
  assign take    = q_valid_i && (q_data_i.is_load || room);
  assign q_pop_o = take;
  assign do_read = take && !q_data_i.is_load;

  fgt_ram #(
    .WIDTH(PIXW),
    .DEPTH(MAX_WIDTH * MAX_HEIGHT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (take && q_data_i.is_load),
    .waddr_i(q_data_i.addr),
    .wdata_i(q_data_i.pix),
    .re_i   (do_read),
    .raddr_i(q_data_i.addr),
    .rdata_o(rdata)
  );

  assign opush = pend_q;
  assign opop  = pop_i && (ocnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= '0;
    end else begin
      pend_q <= do_read;
      if (opush) owp_q <= ~owp_q;
      if (opop) orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      pend_err_q  <= q_data_i.err;
      pend_last_q <= q_data_i.last;
    end
    if (opush) begin
      opix_q[owp_q]  <= pend_err_q ? '0 : rdata;
      olast_q[owp_q] <= pend_last_q;
      oerr_q[owp_q]  <= pend_err_q;
    end
  end

  assign empty_o     = (ocnt_q == '0);
  assign out_red_o   = opix_q[orp_q][23:16];
  assign out_green_o = opix_q[orp_q][15:8];
  assign out_blue_o  = opix_q[orp_q][7:0];
  assign last_o      = olast_q[orp_q];
  assign error_o     = oerr_q[orp_q];

endmodule

// ----- rtl/frame_geometric_transform.sv -----
// Channel   Handshake                  Payload
// input     push / full                op_i, in_red_i, in_green_i, in_blue_i
// result    empty / pop                out_red_o, out_green_o, out_blue_o, last_o, error_o
// config    psel/penable/pwrite/pready paddr (reg i at 4*i), pwdata, prdata
//
// The front takes one beat at a time: a load or a misfit crop fetch goes to the push
// state, a fetch to the multiply state and then the push state, and a scale fetch takes
// 18 restoring-divider steps before those; a fetch in a spare mode is dropped without a command.
// A two-entry command queue feeds the back, which writes or reads the frame RAM;
// a read result is registered by the RAM, then lands in a two-entry output queue.
// Reset clears positions, pointers and queues; the frame RAM is not cleared.
// A stalled result side backs up through both queues until full rises.
`include "frame_geometric_transform_assert.svh"

module frame_geometric_transform (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        last_o,
  output logic        error_o
);
  import fgt_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic       q_push, q_full, q_pop, q_valid;
  cmd_t       q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register file: hold values between writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= MODE_FLIP_H;
      cfg_q.in_width   <= SZW'(256);
      cfg_q.in_height  <= SZW'(256);
      cfg_q.out_width  <= SZW'(256);
      cfg_q.out_height <= SZW'(256);
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:       cfg_q.mode       <= pwdata[2:0];
        REG_IN_WIDTH:   cfg_q.in_width   <= pwdata[SZW-1:0];
        REG_IN_HEIGHT:  cfg_q.in_height  <= pwdata[SZW-1:0];
        REG_OUT_WIDTH:  cfg_q.out_width  <= pwdata[SZW-1:0];
        REG_OUT_HEIGHT: cfg_q.out_height <= pwdata[SZW-1:0];
        REG_ORIGIN_X:   cfg_q.origin_x   <= pwdata[7:0];
        REG_ORIGIN_Y:   cfg_q.origin_y   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:       prdata = 32'(cfg_q.mode);
      REG_IN_WIDTH:   prdata = 32'(cfg_q.in_width);
      REG_IN_HEIGHT:  prdata = 32'(cfg_q.in_height);
      REG_OUT_WIDTH:  prdata = 32'(cfg_q.out_width);
      REG_OUT_HEIGHT: prdata = 32'(cfg_q.out_height);
      REG_ORIGIN_X:   prdata = 32'(cfg_q.origin_x);
      REG_ORIGIN_Y:   prdata = 32'(cfg_q.origin_y);
      default:        prdata = '0;
    endcase
  end

  // Front: classify the beat, compute the source address.
  fgt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .op_i      (op_i),
    .in_red_i  (in_red_i),
    .in_green_i(in_green_i),
    .in_blue_i (in_blue_i),
    .busy_o    (full),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  // Decouple front and back.
  fgt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  // Back: access the frame RAM and queue results.
  fgt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

  `FGT_ASSERT_NOW(a_err_result, !empty && error_o, last_o && out_red_o == 8'd0 && out_green_o == 8'd0 && out_blue_o == 8'd0)
  `FGT_ASSERT_NEXT(a_load_busy, push && !full && op_i == OP_LOAD, full)
  `FGT_ASSERT_NEXT(a_mode_write, cfg_wr && reg_idx == REG_MODE, cfg_q.mode == $past(pwdata[2:0]))

endmodule
